// File: rtl/core/swt_pkg.sv
package swt_pkg;

  // token kinds on the result side
  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_NUMBER  = 3'd1;
  localparam logic [2:0] KIND_ECHO    = 3'd2;
  localparam logic [2:0] KIND_INVALID = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  // scanner modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_ECHO   = 2'd3;

  localparam int unsigned MaxResults = 4;
  localparam logic [7:0] CharUnderscore = 8'h5f;

  // one output beat
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tbyte;
    logic       first;
    logic       last;
  } result_t;

  // all beats caused by one input byte
  typedef struct packed {
    logic [2:0]               count;
    result_t [MaxResults-1:0] res;
  } burst_t;

  // letters of the echo keyword, by position
  function automatic logic [7:0] echo_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0: c = 8'h65;
      2'd1: c = 8'h63;
      2'd2: c = 8'h68;
      default: c = 8'h6f;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_ident_cont(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CharUnderscore);
  endfunction

endpackage

// File: rtl/core/swt_lex.sv
module swt_lex (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       ch,
  input  logic             end_of_input,
  output swt_pkg::burst_t  burst
);

  logic [1:0] token_mode, token_mode_next;
  logic [1:0] echo_progress, echo_progress_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic       held_is_first, held_is_first_next;

  // scan one byte: next state and the beats it releases
  always_comb begin
    logic [2:0] n;
    logic       restart;
    logic       cont;
    logic [2:0] wkind;
    logic [1:0] p;
    n = 3'd0;
    restart = 1'b0;
    cont = 1'b0;
    wkind = (token_mode == swt_pkg::MODE_IDENT) ? swt_pkg::KIND_IDENT : swt_pkg::KIND_NUMBER;
    p = echo_progress;
    burst = '0;
    token_mode_next = token_mode;
    echo_progress_next = echo_progress;
    held_byte_next = held_byte;
    held_valid_next = held_valid;
    held_is_first_next = held_is_first;

    if (end_of_input) begin
      // flush whatever is pending, then the end token
      if (token_mode == swt_pkg::MODE_ECHO) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < p) begin
            burst.res[n[1:0]] = '{swt_pkg::KIND_IDENT, swt_pkg::echo_char(2'(i)),
                                  i == 0, 2'(i + 1) == p};
            n = n + 3'd1;
          end
        end
      end else if (token_mode != swt_pkg::MODE_IDLE && held_valid) begin
        burst.res[n[1:0]] = '{wkind, held_byte, held_is_first, 1'b1};
        n = n + 3'd1;
      end
      token_mode_next = swt_pkg::MODE_IDLE;
      echo_progress_next = 2'd0;
      held_byte_next = 8'd0;
      held_valid_next = 1'b0;
      held_is_first_next = 1'b0;
      burst.res[n[1:0]] = '{swt_pkg::KIND_END, 8'd0, 1'b1, 1'b1};
      n = n + 3'd1;
    end else begin
      case (token_mode)
        swt_pkg::MODE_IDENT, swt_pkg::MODE_NUMBER: begin
          cont = (token_mode == swt_pkg::MODE_IDENT) ? swt_pkg::is_ident_cont(ch)
                                                     : swt_pkg::is_digit(ch);
          if (held_valid) begin
            burst.res[n[1:0]] = '{wkind, held_byte, held_is_first, !cont};
            n = n + 3'd1;
          end
          if (cont) begin
            held_byte_next = ch;
            held_is_first_next = !held_valid;
            held_valid_next = 1'b1;
          end else begin
            restart = 1'b1;
          end
        end
        swt_pkg::MODE_ECHO: begin
          if (ch == swt_pkg::echo_char(p)) begin
            if (p == 2'd3) begin
              for (int i = 0; i < 4; i++) begin
                burst.res[2'(i)] = '{swt_pkg::KIND_ECHO, swt_pkg::echo_char(2'(i)),
                                     i == 0, i == 3};
              end
              n = 3'd4;
              token_mode_next = swt_pkg::MODE_IDLE;
              echo_progress_next = 2'd0;
              held_byte_next = 8'd0;
              held_valid_next = 1'b0;
              held_is_first_next = 1'b0;
            end else begin
              echo_progress_next = p + 2'd1;
            end
          end else begin
            cont = swt_pkg::is_ident_cont(ch);
            // matched prefix falls back to identifier bytes
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < p) begin
                burst.res[n[1:0]] = '{swt_pkg::KIND_IDENT, swt_pkg::echo_char(2'(i)),
                                      i == 0, !cont && (2'(i + 1) == p)};
                n = n + 3'd1;
              end
            end
            if (cont) begin
              token_mode_next = swt_pkg::MODE_IDENT;
              echo_progress_next = 2'd0;
              held_byte_next = ch;
              held_valid_next = 1'b1;
              held_is_first_next = (p == 2'd0);
            end else begin
              restart = 1'b1;
            end
          end
        end
        default: restart = 1'b1;
      endcase

      // byte taken as if between tokens
      if (restart) begin
        token_mode_next = swt_pkg::MODE_IDLE;
        echo_progress_next = 2'd0;
        held_byte_next = 8'd0;
        held_valid_next = 1'b0;
        held_is_first_next = 1'b0;
        if (swt_pkg::is_space(ch)) begin
          // separator only
        end else if (ch == swt_pkg::echo_char(2'd0)) begin
          token_mode_next = swt_pkg::MODE_ECHO;
          echo_progress_next = 2'd1;
        end else if (swt_pkg::is_ident_cont(ch)) begin
          token_mode_next = swt_pkg::is_digit(ch) ? swt_pkg::MODE_NUMBER : swt_pkg::MODE_IDENT;
          held_byte_next = ch;
          held_valid_next = 1'b1;
          held_is_first_next = 1'b1;
        end else begin
          burst.res[n[1:0]] = '{swt_pkg::KIND_INVALID, ch, 1'b1, 1'b1};
          n = n + 3'd1;
        end
      end
    end
    burst.count = n;
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      token_mode <= swt_pkg::MODE_IDLE;
      echo_progress <= 2'd0;
      held_byte <= 8'd0;
      held_valid <= 1'b0;
      held_is_first <= 1'b0;
    end else if (accept) begin
      token_mode <= token_mode_next;
      echo_progress <= echo_progress_next;
      held_byte <= held_byte_next;
      held_valid <= held_valid_next;
      held_is_first <= held_is_first_next;
    end
  end

endmodule

// File: rtl/core/swt_burst.sv
module swt_burst (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  swt_pkg::burst_t  burst,
  input  logic             pop,
  output logic             room,
  output logic             valid,
  output swt_pkg::result_t head_res,
  output logic             head_last
);

  swt_pkg::result_t [swt_pkg::MaxResults-1:0] entries;
  logic [2:0] avail;
  logic [1:0] head;

  assign valid = (avail != 3'd0);
  assign head_res = entries[head];
  assign head_last = (avail == 3'd1);
  // take a new burst when the buffer is empty or the last pending beat leaves this cycle
  assign room = (avail == 3'd0) || ((avail == 3'd1) && pop);

  // beat payloads
  always_ff @(posedge clk) begin
    if (load) begin
      entries <= burst.res;
    end
  end

  // drain pointer and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= 3'd0;
      head <= 2'd0;
    end else if (load) begin
      avail <= burst.count;
      head <= 2'd0;
    end else if (pop) begin
      avail <= avail - 3'd1;
      head <= 2'(head + 2'd1);
    end
  end

  a_avail_range: assert property (@(posedge clk) disable iff (rst)
    avail <= 3'd4) else $error("burst fill level out of range");
  a_load_level: assert property (@(posedge clk) disable iff (rst)
    load |=> avail == $past(burst.count)) else $error("burst load lost");
  a_pop_level: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> avail == $past(avail) - 3'd1) else $error("beat drain miscounted");
  a_hold_head: assert property (@(posedge clk) disable iff (rst)
    (valid && !pop && !load) |=> $stable(head) && $stable(avail))
    else $error("stalled beat moved");

endmodule

// File: rtl/core/shell_word_tokenizer.sv
// Streaming word tokenizer for a small shell language. One ASCII byte enters
// per beat on the s_ side (s_tlast high marks end of text; its byte is
// ignored) and every token byte leaves as one m_ beat tagged with its kind,
// first flag, last flag (m_tlast) and a flag on the final beat caused by that
// input byte. A byte is scanned in the cycle it is accepted and its 0 to 4
// beats land in a four-entry result buffer, which drains one beat per cycle
// while m_tready is high. A new byte is accepted whenever that buffer is empty
// or its final beat is being taken, so throughput is one byte per cycle while
// each byte yields at most one beat and m_tready stays high; a byte yielding
// more beats holds the input until the single output port of the buffer has
// taken its final beat. The first beat appears in the cycle after accept.
module shell_word_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] token_byte, [8] first_of_token, [9] last_result
  output logic [2:0]  m_tuser,   // [2:0] token_kind
  output logic        m_tlast    // last_of_token
);

  logic             room;
  logic             accept;
  logic             pop;
  logic             head_last;
  swt_pkg::burst_t  burst;
  swt_pkg::result_t head_res;

  assign s_tready = room;
  assign accept = s_tvalid && room;
  assign pop = m_tvalid && m_tready;

  swt_lex u_lex (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .ch           (s_tdata),
    .end_of_input (s_tlast),
    .burst        (burst)
  );

  swt_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && (burst.count != 3'd0)),
    .burst     (burst),
    .pop       (pop),
    .room      (room),
    .valid     (m_tvalid),
    .head_res  (head_res),
    .head_last (head_last)
  );

  // pack the head beat
  assign m_tdata = {6'd0, head_last, head_res.first, head_res.tbyte};
  assign m_tuser = head_res.kind;
  assign m_tlast = head_res.last;

endmodule
